// File: rtl/cau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants of the complex arithmetic unit (signed Q16.16).
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int REM_W     = PROD_W + FRAC_BITS;
	localparam int SHIFT_W   = REM_W + DATA_W;
	localparam int STEPS     = DATA_W;

	typedef enum logic [3:0] {
		CMD_ADD    = 4'd0,
		CMD_SUB    = 4'd1,
		CMD_MUL    = 4'd2,
		CMD_DIV    = 4'd3,
		CMD_DIVR   = 4'd4,
		CMD_MAG    = 4'd5,
		CMD_CONJ   = 4'd6,
		CMD_CMP    = 4'd7,
		CMD_INC_RE = 4'd8,
		CMD_DEC_RE = 4'd9,
		CMD_INC_IM = 4'd10,
		CMD_DEC_IM = 4'd11
	} cmd_t;

	typedef struct packed {
		logic [3:0]               command;
		logic signed [DATA_W-1:0] a_re;
		logic signed [DATA_W-1:0] a_im;
		logic signed [DATA_W-1:0] b_re;
		logic signed [DATA_W-1:0] b_im;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] res_re;
		logic signed [DATA_W-1:0] res_im;
		logic [DATA_W-1:0]        magnitude;
		logic                     mag_equal;
		logic                     mag_less;
		logic                     mag_greater;
		logic                     overflow;
		logic                     div_zero;
	} rsp_t;

	// results settled early, carried alongside the iterative lanes
	typedef struct packed {
		cmd_t              cmd;
		logic [DATA_W-1:0] rr;
		logic [DATA_W-1:0] ri;
		logic              ov;
		logic              dz;
		logic              eq;
		logic              lt;
		logic              gt;
		logic              neg_re;
		logic              neg_im;
		logic              big_re;
		logic              big_im;
	} side_t;

	typedef struct packed {
		side_t             side;
		logic [PROD_W-1:0] den;
		logic [REM_W-1:0]  rem_re;
		logic [REM_W-1:0]  rem_im;
		logic [DATA_W-1:0] q_re;
		logic [DATA_W-1:0] q_im;
		logic [PROD_W-1:0] sq_x;
		logic [PROD_W-1:0] sq_res;
	} iter_t;

endpackage
`default_nettype wire

// File: rtl/cau_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Three stages: products, sums and operand selection, saturation and
// divider / root set-up.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  req_t  in_data,
	output logic  out_valid,
	output iter_t out_data
);

	typedef struct packed {
		logic              ov;
		logic [DATA_W-1:0] v;
	} sat_t;

	localparam logic signed [SUM_W-1:0] MAX_POS = SUM_W'((PROD_W'(1) << (DATA_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] MIN_NEG = -SUM_W'(PROD_W'(1) << (DATA_W - 1));

	function automatic sat_t sat_fn(input logic signed [SUM_W-1:0] v);
		sat_t r;
		r.ov = 1'b0;
		r.v  = v[DATA_W-1:0];
		if (v > MAX_POS) begin
			r.ov = 1'b1;
			r.v  = MAX_POS[DATA_W-1:0];
		end else if (v < MIN_NEG) begin
			r.ov = 1'b1;
			r.v  = MIN_NEG[DATA_W-1:0];
		end
		return r;
	endfunction

	// ---- stage 1 ----
	cmd_t                     cmd_c;
	logic signed [SUM_W-1:0]  ar_x, ai_x, br_x, bi_x, one_x, s_re, s_im;
	sat_t                     sat_re1, sat_im1;
	side_t                    side_c1;

	logic                     v_s1;
	cmd_t                     cmd_s1;
	side_t                    side_s1;
	logic signed [PROD_W-1:0] arbr_s1, aibi_s1, aibr_s1, arbi_s1;
	logic signed [PROD_W-1:0] arar_s1, aiai_s1, brbr_s1, bibi_s1;
	logic signed [DATA_W-1:0] ar_s1, ai_s1, br_s1;

	always_comb begin
		cmd_c = cmd_t'(in_data.command);
		ar_x  = SUM_W'(in_data.a_re);
		ai_x  = SUM_W'(in_data.a_im);
		br_x  = SUM_W'(in_data.b_re);
		bi_x  = SUM_W'(in_data.b_im);
		one_x = SUM_W'(PROD_W'(1) << FRAC_BITS);
		case (cmd_c)
			CMD_ADD: begin
				s_re = ar_x + br_x;
				s_im = ai_x + bi_x;
			end
			CMD_SUB: begin
				s_re = ar_x - br_x;
				s_im = ai_x - bi_x;
			end
			CMD_CONJ: begin
				s_re = ar_x;
				s_im = -ai_x;
			end
			CMD_INC_RE: begin
				s_re = ar_x + one_x;
				s_im = ai_x;
			end
			CMD_DEC_RE: begin
				s_re = ar_x - one_x;
				s_im = ai_x;
			end
			CMD_INC_IM: begin
				s_re = ar_x;
				s_im = ai_x + one_x;
			end
			CMD_DEC_IM: begin
				s_re = ar_x;
				s_im = ai_x - one_x;
			end
			default: begin
				s_re = '0;
				s_im = '0;
			end
		endcase
		sat_re1 = sat_fn(s_re);
		sat_im1 = sat_fn(s_im);

		side_c1     = '0;
		side_c1.cmd = cmd_c;
		side_c1.rr  = sat_re1.v;
		side_c1.ri  = sat_im1.v;
		side_c1.ov  = sat_re1.ov | sat_im1.ov;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1         <= cmd_c;
			side_s1        <= side_c1;
			arbr_s1        <= in_data.a_re * in_data.b_re;
			aibi_s1        <= in_data.a_im * in_data.b_im;
			aibr_s1        <= in_data.a_im * in_data.b_re;
			arbi_s1        <= in_data.a_re * in_data.b_im;
			arar_s1        <= in_data.a_re * in_data.a_re;
			aiai_s1        <= in_data.a_im * in_data.a_im;
			brbr_s1        <= in_data.b_re * in_data.b_re;
			bibi_s1        <= in_data.b_im * in_data.b_im;
			ar_s1          <= in_data.a_re;
			ai_s1          <= in_data.a_im;
			br_s1          <= in_data.b_re;
		end
	end

	// ---- stage 2 ----
	logic signed [SUM_W-1:0] num_re_c, num_im_c;
	logic [PROD_W-1:0]       den_c, magb_c;

	logic                    v_s2;
	cmd_t                    cmd_s2;
	side_t                   side_s2;
	logic signed [SUM_W-1:0] mre_s2, mim_s2, num_re_s2, num_im_s2;
	logic [PROD_W-1:0]       den_s2, maga_s2, magb_s2;

	always_comb begin
		magb_c = $unsigned(brbr_s1) + $unsigned(bibi_s1);
		if (cmd_s1 == CMD_DIVR) begin
			den_c    = br_s1[DATA_W-1] ? PROD_W'($unsigned(-SUM_W'(br_s1)))
			                           : PROD_W'($unsigned(br_s1));
			num_re_c = br_s1[DATA_W-1] ? -SUM_W'(ar_s1) : SUM_W'(ar_s1);
			num_im_c = br_s1[DATA_W-1] ? -SUM_W'(ai_s1) : SUM_W'(ai_s1);
		end else begin
			den_c    = magb_c;
			num_re_c = SUM_W'(arbr_s1) + SUM_W'(aibi_s1);
			num_im_c = SUM_W'(aibr_s1) - SUM_W'(arbi_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2    <= cmd_s1;
			side_s2   <= side_s1;
			mre_s2    <= SUM_W'(arbr_s1) - SUM_W'(aibi_s1);
			mim_s2    <= SUM_W'(aibr_s1) + SUM_W'(arbi_s1);
			num_re_s2 <= num_re_c;
			num_im_s2 <= num_im_c;
			den_s2    <= den_c;
			maga_s2   <= $unsigned(arar_s1) + $unsigned(aiai_s1);
			magb_s2   <= magb_c;
		end
	end

	// ---- stage 3 ----
	sat_t                    sat_re3, sat_im3;
	logic signed [SUM_W-1:0] abs_re, abs_im;
	logic [REM_W-1:0]        rem_re_c, rem_im_c;
	logic [SHIFT_W-1:0]      den_top;
	side_t                   side_c;
	logic                    is_div;
	iter_t                   d_c;

	logic                    v_s3;
	iter_t                   d_s3;

	always_comb begin
		// floor shift of the exact product sum
		sat_re3  = sat_fn(mre_s2 >>> FRAC_BITS);
		sat_im3  = sat_fn(mim_s2 >>> FRAC_BITS);
		abs_re   = num_re_s2[SUM_W-1] ? -num_re_s2 : num_re_s2;
		abs_im   = num_im_s2[SUM_W-1] ? -num_im_s2 : num_im_s2;
		rem_re_c = {abs_re[PROD_W-1:0], {FRAC_BITS{1'b0}}};
		rem_im_c = {abs_im[PROD_W-1:0], {FRAC_BITS{1'b0}}};
		den_top  = SHIFT_W'({den_s2, {DATA_W{1'b0}}});
		is_div   = (cmd_s2 == CMD_DIV) || (cmd_s2 == CMD_DIVR);

		side_c        = side_s2;
		side_c.neg_re = num_re_s2[SUM_W-1];
		side_c.neg_im = num_im_s2[SUM_W-1];
		// quotient of 2^DATA_W or more always saturates
		side_c.big_re = SHIFT_W'(rem_re_c) >= den_top;
		side_c.big_im = SHIFT_W'(rem_im_c) >= den_top;
		side_c.dz     = is_div && (den_s2 == '0);
		if (cmd_s2 == CMD_MUL) begin
			side_c.rr = sat_re3.v;
			side_c.ri = sat_im3.v;
			side_c.ov = sat_re3.ov | sat_im3.ov;
		end
		if (cmd_s2 == CMD_CMP) begin
			side_c.eq = maga_s2 == magb_s2;
			side_c.lt = maga_s2 < magb_s2;
			side_c.gt = maga_s2 > magb_s2;
		end

		d_c        = '0;
		d_c.side   = side_c;
		d_c.den    = den_s2;
		d_c.rem_re = rem_re_c;
		d_c.rem_im = rem_im_c;
		d_c.sq_x   = maga_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= d_c;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;

endmodule
`default_nettype wire

// File: rtl/cau_iter_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_iter_stage
// One registered step of both restoring divider lanes and the square root.
// ----------------------------------------------------------------------------
module cau_iter_stage import cau_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  iter_t in_data,
	output logic  out_valid,
	output iter_t out_data
);

	localparam int SH = STEPS - 1 - STEP;

	logic [SHIFT_W-1:0] dsh, rx_re, rx_im;
	logic [PROD_W-1:0]  bit_c, trial;
	iter_t              nxt;
	logic               v_q;
	iter_t              d_q;

	always_comb begin
		nxt   = in_data;
		dsh   = SHIFT_W'(in_data.den) << SH;
		rx_re = SHIFT_W'(in_data.rem_re);
		rx_im = SHIFT_W'(in_data.rem_im);
		if (rx_re >= dsh) begin
			nxt.rem_re   = REM_W'(rx_re - dsh);
			nxt.q_re[SH] = 1'b1;
		end
		if (rx_im >= dsh) begin
			nxt.rem_im   = REM_W'(rx_im - dsh);
			nxt.q_im[SH] = 1'b1;
		end
		// digit by digit root, one result bit per step
		bit_c = PROD_W'(1) << (2 * SH);
		trial = in_data.sq_res + bit_c;
		if (in_data.sq_x >= trial) begin
			nxt.sq_x   = in_data.sq_x - trial;
			nxt.sq_res = (in_data.sq_res >> 1) + bit_c;
		end else begin
			nxt.sq_res = in_data.sq_res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign out_data  = d_q;

endmodule
`default_nettype wire

// File: rtl/cau_finish.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_finish
// Quotient sign and saturation, and selection of the result beat fields.
// ----------------------------------------------------------------------------
module cau_finish import cau_pkg::*; (
	input  iter_t in_data,
	output rsp_t  out_data
);

	localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W - 1){1'b1}}};
	localparam logic [DATA_W-1:0] MIN_MAG = {1'b1, {(DATA_W - 1){1'b0}}};

	logic              ov_re, ov_im;
	logic [DATA_W-1:0] qr, qi;

	always_comb begin
		ov_re = in_data.side.big_re ||
		        (in_data.q_re > (in_data.side.neg_re ? MIN_MAG : MAX_POS));
		ov_im = in_data.side.big_im ||
		        (in_data.q_im > (in_data.side.neg_im ? MIN_MAG : MAX_POS));
		if (in_data.side.neg_re) begin
			qr = ov_re ? MIN_MAG : -in_data.q_re;
		end else begin
			qr = ov_re ? MAX_POS : in_data.q_re;
		end
		if (in_data.side.neg_im) begin
			qi = ov_im ? MIN_MAG : -in_data.q_im;
		end else begin
			qi = ov_im ? MAX_POS : in_data.q_im;
		end

		out_data             = '0;
		out_data.mag_equal   = in_data.side.eq;
		out_data.mag_less    = in_data.side.lt;
		out_data.mag_greater = in_data.side.gt;
		case (in_data.side.cmd)
			CMD_DIV, CMD_DIVR: begin
				if (in_data.side.dz) begin
					out_data.div_zero = 1'b1;
				end else begin
					out_data.res_re   = qr;
					out_data.res_im   = qi;
					out_data.overflow = ov_re | ov_im;
				end
			end
			CMD_MAG: begin
				out_data.magnitude = in_data.sq_res[DATA_W-1:0];
			end
			default: begin
				out_data.res_re   = in_data.side.rr;
				out_data.res_im   = in_data.side.ri;
				out_data.overflow = in_data.side.ov;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/complex_arithmetic_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Pipelined complex ALU in signed Q16.16 with saturation and divide-by-zero.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_t (command, a_re..b_im)
//   rsp      out        rsp_valid / rsp_ready  rsp_t (res_re..div_zero)
//
// One beat per cycle unless the pipeline holds; it has 3 set-up stages, 32
// stages of the shared divide / root step (one bit of each quotient and one
// root bit per stage) and the output register. Reset clears only valid bits.
// A skid register behind the output takes one more beat while rsp stalls;
// req_ready drops only once it is full, and the whole pipeline then holds.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top import cau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic  en;
	logic  v_chain [0:STEPS];
	iter_t d_chain [0:STEPS];
	rsp_t  fin;
	logic  out_valid_q, skid_valid_q;
	rsp_t  out_q, skid_q;
	logic  out_free;

	assign en        = !skid_valid_q;
	assign req_ready = en;

	cau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (req_valid),
		.in_data  (req),
		.out_valid(v_chain[0]),
		.out_data (d_chain[0])
	);

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		cau_iter_stage #(.STEP(j)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v_chain[j]),
			.in_data  (d_chain[j]),
			.out_valid(v_chain[j+1]),
			.out_data (d_chain[j+1])
		);
	end

	cau_finish u_finish (
		.in_data (d_chain[STEPS]),
		.out_data(fin)
	);

	assign out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (rsp_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (v_chain[STEPS]) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (rsp_ready) begin
				out_q <= skid_q;
			end
		end else if (v_chain[STEPS]) begin
			if (out_free) begin
				out_q <= fin;
			end else begin
				skid_q <= fin;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// skid only fills behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid beat without output beat");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.div_zero |-> rsp.res_re == '0 && rsp.res_im == '0 && !rsp.overflow)
		else $error("divide by zero with non-zero result");

	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0({rsp.mag_equal, rsp.mag_less, rsp.mag_greater}))
		else $error("more than one compare flag");

	// a full skid drains before a new beat can leave the pipeline
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && rsp_ready |=> !skid_valid_q)
		else $error("skid not drained");

endmodule
`default_nettype wire
